>>> hw/rtl/rrbm_pkg.sv
// Shared types and constants for the cartridge ROM/RAM bank mapper.
`timescale 1ns / 1ps
`default_nettype none
package rrbm_pkg;

  // Access kind on the input side.
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Result source codes.
  localparam logic [1:0] SRC_ROM   = 2'd0;
  localparam logic [1:0] SRC_DATA  = 2'd1;
  localparam logic [1:0] SRC_WRITE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ROM_BANK_MASK = 2'd0;
  localparam logic [1:0] CFG_RAM_BANK_MASK = 2'd1;
  localparam logic [1:0] CFG_RAM_PRESENT   = 2'd2;

  // Bus address regions, in 8 KiB steps (bus_address[15:13]).
  localparam logic [2:0] RGN_RAM_ENABLE = 3'd0;
  localparam logic [2:0] RGN_ROM_BANK   = 3'd1;
  localparam logic [2:0] RGN_RAM_BANK   = 3'd2;
  localparam logic [2:0] RGN_MODE       = 3'd3;
  localparam logic [2:0] RGN_EXT_RAM    = 3'd5;

  localparam int          ROM_BANK_BYTES = 16384;
  localparam int          ROM_OFF_W      = $clog2(ROM_BANK_BYTES);
  localparam int          ROM_BANK_W     = 5;
  localparam int          ROM_ADDR_W     = ROM_OFF_W + ROM_BANK_W;
  localparam int          RAM_BANK_W     = 2;
  localparam int          RAM_WIN_W      = 13;
  localparam int          CFG_DATA_W     = 5;
  localparam logic [7:0]  RAM_ENABLE_KEY = 8'h0A;
  localparam logic [7:0]  OPEN_BUS       = 8'hFF;

  // One classified access as handed from the front end to the back end.
  typedef struct packed {
    logic [1:0]            source;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic [7:0]            read_data;
    logic                  ram_rd;
    logic                  ram_wr;
    logic [7:0]            write_data;
  } op_t;

  // One finished result.
  typedef struct packed {
    logic [1:0]            source;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic [7:0]            read_data;
  } res_t;

endpackage
`default_nettype wire

>>> hw/rtl/rom_ram_bank_mapper.sv
// Cartridge ROM/RAM bank mapper top level.
// Accesses pass the mid queue and the back end's result register into the result queue.
// One access per cycle unless a queue stalls; RAM port and result queue used once per access.
// Front-end bank registers are updated at the accept edge of each write to regions 0 to 3.
// Reset (rst_n low, synchronous) empties both queues and restores bank and config registers.
// External RAM contents are not cleared by reset.
`timescale 1ns / 1ps
`default_nettype none
module rom_ram_bank_mapper #(
  parameter int ROM_BANK_BITS  = 5,
  parameter int RAM_BANK_BYTES = 8192
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_push,
  output logic                                     in_full,
  input  wire logic                                in_action,
  input  wire logic [15:0]                         in_bus_address,
  input  wire logic [7:0]                          in_write_data,
  output logic                                     out_empty,
  input  wire logic                                out_pop,
  output logic      [1:0]                          out_source,
  output logic      [rrbm_pkg::ROM_ADDR_W-1:0]     out_rom_address,
  output logic      [7:0]                          out_read_data,
  input  wire logic                                cfg_wr_en,
  input  wire logic [1:0]                          cfg_index,
  input  wire logic [rrbm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int RAM_DEPTH = 4 * RAM_BANK_BYTES;
  localparam int IDX_W     = $clog2(RAM_DEPTH);
  localparam int MID_AW    = 1;
  localparam int OUT_AW    = 2;
  localparam int MID_W     = $bits(rrbm_pkg::op_t) + IDX_W;
  localparam int RES_W     = $bits(rrbm_pkg::res_t);

  logic               mid_push, mid_pop, mid_full, mid_empty;
  rrbm_pkg::op_t      front_op, back_op;
  logic [IDX_W-1:0]   front_idx, back_idx;
  logic [MID_W-1:0]   mid_rdata;
  logic [MID_AW:0]    mid_count;
  logic               res_push, res_full;
  rrbm_pkg::res_t     res_in, res_out;
  logic [RES_W-1:0]   res_rdata;
  logic [OUT_AW:0]    res_count;

  assign in_full = mid_full;

  rrbm_front #(
    .ROM_BANK_BITS (ROM_BANK_BITS),
    .RAM_BANK_BYTES(RAM_BANK_BYTES),
    .IDX_W         (IDX_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_action     (in_action),
    .in_bus_address(in_bus_address),
    .in_write_data (in_write_data),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mid_full      (mid_full),
    .mid_push      (mid_push),
    .mid_op        (front_op),
    .mid_idx       (front_idx)
  );

  rrbm_fifo #(
    .WIDTH(MID_W),
    .AW   (MID_AW)
  ) u_mid_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (mid_push),
    .wdata({front_op, front_idx}),
    .pop  (mid_pop),
    .rdata(mid_rdata),
    .full (mid_full),
    .empty(mid_empty),
    .count(mid_count)
  );

  assign {back_op, back_idx} = mid_rdata;

  rrbm_back #(
    .RAM_DEPTH(RAM_DEPTH),
    .IDX_W    (IDX_W),
    .OUT_AW   (OUT_AW)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (!mid_empty),
    .op       (back_op),
    .op_idx   (back_idx),
    .op_pop   (mid_pop),
    .res_count(res_count),
    .res_push (res_push),
    .res      (res_in)
  );

  rrbm_fifo #(
    .WIDTH(RES_W),
    .AW   (OUT_AW)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res_in),
    .pop  (out_pop),
    .rdata(res_rdata),
    .full (res_full),
    .empty(out_empty),
    .count(res_count)
  );

  assign res_out         = res_rdata;
  assign out_source      = res_out.source;
  assign out_rom_address = res_out.rom_address;
  assign out_read_data   = res_out.read_data;

  // The back end must never deliver a result into a full result queue.
  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result queue overflow");

  // The back end only issues when the mid queue holds an access.
  a_mid_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |-> (mid_count != '0))
    else $error("back end issued from an empty mid queue");

  // An issued access becomes a queued result on the next cycle.
  a_issue_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |=> res_push)
    else $error("issued access did not produce a result");

  // A write result carries neither a ROM address nor a data byte.
  a_result_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && (res_in.source == rrbm_pkg::SRC_WRITE)) |->
      ((res_in.rom_address == '0) && (res_in.read_data == '0)))
    else $error("write result carries payload");

endmodule
`default_nettype wire

>>> hw/rtl/rrbm_fifo.sv
// Small flop-based FIFO used for the mid queue and the result queue.
`timescale 1ns / 1ps
`default_nettype none
module rrbm_fifo #(
  parameter int WIDTH = 8,
  parameter int AW    = 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  full,
  output logic                  empty,
  output logic      [AW:0]      count
);

  localparam int DEPTH = 2 ** AW;

  logic [WIDTH-1:0] data_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign full  = (count_r == (AW + 1)'(DEPTH));
  assign empty = (count_r == '0);
  assign count = count_r;
  assign rdata = data_r[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/rrbm_front.sv
// Front end: accepts bus accesses, updates the bank registers and classifies each access.
`timescale 1ns / 1ps
`default_nettype none
module rrbm_front #(
  parameter int ROM_BANK_BITS  = 5,
  parameter int RAM_BANK_BYTES = 8192,
  parameter int IDX_W          = 15
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_push,
  input  wire logic                             in_action,
  input  wire logic [15:0]                      in_bus_address,
  input  wire logic [7:0]                       in_write_data,
  input  wire logic                             cfg_wr_en,
  input  wire logic [1:0]                       cfg_index,
  input  wire logic [rrbm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             mid_full,
  output logic                                  mid_push,
  output rrbm_pkg::op_t                         mid_op,
  output logic      [IDX_W-1:0]                 mid_idx
);

  // Largest whole number of RAM banks that fit below the window offset.
  localparam int MAXQ = (2 ** rrbm_pkg::RAM_WIN_W - 1) / RAM_BANK_BYTES;

  logic                                ram_enable_r;
  logic [rrbm_pkg::ROM_BANK_W-1:0]     rom_bank_r;
  logic [rrbm_pkg::RAM_BANK_W-1:0]     ram_bank_r;
  logic                                banking_mode_r;
  logic [rrbm_pkg::ROM_BANK_W-1:0]     rom_bank_mask_r;
  logic [rrbm_pkg::RAM_BANK_W-1:0]     ram_bank_mask_r;
  logic                                ram_present_r;

  logic                                accept;
  logic [2:0]                          region;
  logic                                ram_usable;
  logic                                in_ram_win;
  logic [rrbm_pkg::ROM_BANK_W-1:0]     rom_bank_eff;
  logic [rrbm_pkg::ROM_BANK_W-1:0]     rom_bank_wr;
  logic [rrbm_pkg::RAM_BANK_W-1:0]     ram_bank_eff;
  logic [rrbm_pkg::RAM_WIN_W-1:0]      win_off;
  logic [rrbm_pkg::RAM_WIN_W-1:0]      bank_off;

  assign accept     = in_push && !mid_full;
  assign mid_push   = accept;
  assign region     = in_bus_address[15:13];
  assign ram_usable = ram_enable_r && ram_present_r;
  assign in_ram_win = (region == rrbm_pkg::RGN_EXT_RAM);

  assign rom_bank_eff = rom_bank_r & rom_bank_mask_r;
  assign ram_bank_eff = banking_mode_r ? (ram_bank_r & ram_bank_mask_r) : '0;

  // The zero check applies to the bank bits the cartridge decodes, before the mask.
  always_comb begin
    rom_bank_wr = rrbm_pkg::ROM_BANK_W'(in_write_data[ROM_BANK_BITS-1:0]);
    if (rom_bank_wr == '0) begin
      rom_bank_wr = rrbm_pkg::ROM_BANK_W'(1);
    end
  end

  // Offset within a RAM bank: the window offset reduced modulo the bank size by
  // comparing against each whole multiple of it.
  always_comb begin
    win_off  = in_bus_address[rrbm_pkg::RAM_WIN_W-1:0];
    bank_off = win_off;
    for (int k = 1; k <= MAXQ; k++) begin
      if (win_off >= rrbm_pkg::RAM_WIN_W'(k * RAM_BANK_BYTES)) begin
        bank_off = win_off - rrbm_pkg::RAM_WIN_W'(k * RAM_BANK_BYTES);
      end
    end
    mid_idx = IDX_W'(ram_bank_eff) * IDX_W'(RAM_BANK_BYTES) + IDX_W'(bank_off);
  end

  always_comb begin
    mid_op             = '0;
    mid_op.write_data  = in_write_data;
    mid_op.source      = rrbm_pkg::SRC_WRITE;
    if (in_action == rrbm_pkg::ACT_WRITE) begin
      mid_op.ram_wr = in_ram_win && ram_usable;
    end else if (!in_bus_address[15]) begin
      mid_op.source = rrbm_pkg::SRC_ROM;
      if (in_bus_address[14]) begin
        mid_op.rom_address = {rom_bank_eff, in_bus_address[rrbm_pkg::ROM_OFF_W-1:0]};
      end else begin
        mid_op.rom_address = rrbm_pkg::ROM_ADDR_W'(in_bus_address);
      end
    end else if (in_ram_win && ram_usable) begin
      mid_op.source = rrbm_pkg::SRC_DATA;
      mid_op.ram_rd = 1'b1;
    end else begin
      mid_op.source    = rrbm_pkg::SRC_DATA;
      mid_op.read_data = rrbm_pkg::OPEN_BUS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_enable_r    <= 1'b0;
      rom_bank_r      <= rrbm_pkg::ROM_BANK_W'(1);
      ram_bank_r      <= '0;
      banking_mode_r  <= 1'b0;
      rom_bank_mask_r <= '1;
      ram_bank_mask_r <= '1;
      ram_present_r   <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          rrbm_pkg::CFG_ROM_BANK_MASK: begin
            rom_bank_mask_r <= cfg_data[rrbm_pkg::ROM_BANK_W-1:0];
          end
          rrbm_pkg::CFG_RAM_BANK_MASK: begin
            ram_bank_mask_r <= cfg_data[rrbm_pkg::RAM_BANK_W-1:0];
          end
          rrbm_pkg::CFG_RAM_PRESENT: begin
            ram_present_r <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
      if (accept && (in_action == rrbm_pkg::ACT_WRITE)) begin
        unique case (region)
          rrbm_pkg::RGN_RAM_ENABLE: begin
            ram_enable_r <= (in_write_data == rrbm_pkg::RAM_ENABLE_KEY);
          end
          rrbm_pkg::RGN_ROM_BANK: begin
            rom_bank_r <= rom_bank_wr;
          end
          rrbm_pkg::RGN_RAM_BANK: begin
            ram_bank_r <= in_write_data[rrbm_pkg::RAM_BANK_W-1:0];
          end
          rrbm_pkg::RGN_MODE: begin
            banking_mode_r <= in_write_data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/rrbm_back.sv
// Back end: performs the external RAM access and hands finished results to the result queue.
`timescale 1ns / 1ps
`default_nettype none
module rrbm_back #(
  parameter int RAM_DEPTH = 32768,
  parameter int IDX_W     = 15,
  parameter int OUT_AW    = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              op_valid,
  input  wire rrbm_pkg::op_t     op,
  input  wire logic [IDX_W-1:0]  op_idx,
  output logic                   op_pop,
  input  wire logic [OUT_AW:0]   res_count,
  output logic                   res_push,
  output rrbm_pkg::res_t         res
);

  localparam int OUT_DEPTH = 2 ** OUT_AW;

  logic [7:0]      ram_r [RAM_DEPTH];
  logic            inflight_r;
  rrbm_pkg::res_t  res_r;
  logic            ram_sel_r;
  logic [7:0]      ram_q_r;
  logic [OUT_AW+1:0] committed;

  // Count the result in flight so the queue can never be overrun.
  assign committed = (OUT_AW + 2)'(res_count) + (OUT_AW + 2)'(inflight_r);
  assign op_pop    = op_valid && (committed < (OUT_AW + 2)'(OUT_DEPTH));

  assign res_push        = inflight_r;
  assign res.source      = res_r.source;
  assign res.rom_address = res_r.rom_address;
  assign res.read_data   = ram_sel_r ? ram_q_r : res_r.read_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= 1'b0;
    end else begin
      inflight_r <= op_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      res_r.source      <= op.source;
      res_r.rom_address <= op.rom_address;
      res_r.read_data   <= op.read_data;
      ram_sel_r         <= op.ram_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      if (op.ram_wr) begin
        ram_r[op_idx] <= op.write_data;
      end
      ram_q_r <= ram_r[op_idx];
    end
  end

endmodule
`default_nettype wire

>>> bench/rom_ram_bank_mapper_test.sv
// Self-checking testbench for the cartridge ROM/RAM bank mapper.
`timescale 1ns / 1ps
module rom_ram_bank_mapper_test;

  localparam int LIVE = 0;
  localparam int PLAN = 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int RAM_ENTRIES = 32768;

  typedef struct packed {
    logic        action;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } access_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_push = 1'b0;
  logic                            in_full;
  logic                            in_action = rrbm_pkg::ACT_READ;
  logic [15:0]                     in_bus_address = '0;
  logic [7:0]                      in_write_data = '0;
  logic                            out_empty;
  logic                            out_pop = 1'b0;
  logic [1:0]                      out_source;
  logic [rrbm_pkg::ROM_ADDR_W-1:0] out_rom_address;
  logic [7:0]                      out_read_data;
  logic                            cfg_wr_en = 1'b0;
  logic [1:0]                      cfg_index = '0;
  logic [rrbm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  rom_ram_bank_mapper u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_action       (in_action),
    .in_bus_address  (in_bus_address),
    .in_write_data   (in_write_data),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_source      (out_source),
    .out_rom_address (out_rom_address),
    .out_read_data   (out_read_data),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Two copies of the bank and RAM state: LIVE follows accepted transactions, PLAN runs
  // ahead while stimulus is generated so that no unwritten RAM entry is ever read.
  logic       ram_enabled [2];
  logic [4:0] rom_bank_sel [2];
  logic [1:0] ram_bank_sel [2];
  logic       bank_mode [2];
  logic [7:0] ram_image [2][RAM_ENTRIES];
  bit         ram_written [RAM_ENTRIES];
  logic [4:0] rom_mask = 5'd31;
  logic [1:0] ram_mask = 2'd3;
  logic       ram_fitted = 1'b1;

  access_t         accesses_to_send[$];
  rrbm_pkg::res_t  results_due[$];
  logic [15:0]     recent_ram_addrs[$];
  access_t         driven_access;
  rrbm_pkg::res_t  due_result;
  int              queued_total = 0;
  int              accepted_total = 0;
  int              error_count = 0;
  int              rom_fetches = 0;
  int              data_reads = 0;
  int              writes_done = 0;
  int              full_cycles = 0;
  int              settings_run = 0;
  int              send_idle_pct = 36;
  int              recv_idle_pct = 58;
  int              hold_cycles_left = 0;
  int              cycle_count = 0;
  logic            hold_request = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [14:0] ram_entry(int slot, logic [15:0] addr);
    logic [1:0] bank;
    bank = bank_mode[slot] ? (ram_bank_sel[slot] & ram_mask) : 2'd0;
    return {bank, addr[12:0]};
  endfunction

  // Applies one access to a state copy and returns the result it produces.
  function automatic rrbm_pkg::res_t map_access(int slot, access_t acc);
    rrbm_pkg::res_t r;
    logic           ram_usable;
    logic [4:0]     bank;
    r = '0;
    ram_usable = ram_enabled[slot] && ram_fitted;
    if (acc.action == rrbm_pkg::ACT_WRITE) begin
      r.source = rrbm_pkg::SRC_WRITE;
      case (acc.bus_address[15:13])
        rrbm_pkg::RGN_RAM_ENABLE:
          ram_enabled[slot] = (acc.write_data == rrbm_pkg::RAM_ENABLE_KEY);
        rrbm_pkg::RGN_ROM_BANK: begin
          bank = acc.write_data[4:0];
          rom_bank_sel[slot] = (bank == 5'd0) ? 5'd1 : bank;
        end
        rrbm_pkg::RGN_RAM_BANK: ram_bank_sel[slot] = acc.write_data[1:0];
        rrbm_pkg::RGN_MODE: bank_mode[slot] = acc.write_data[0];
        rrbm_pkg::RGN_EXT_RAM: begin
          if (ram_usable) begin
            ram_image[slot][ram_entry(slot, acc.bus_address)] = acc.write_data;
            if (slot == PLAN) ram_written[ram_entry(slot, acc.bus_address)] = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (!acc.bus_address[15]) begin
      r.source = rrbm_pkg::SRC_ROM;
      if (!acc.bus_address[14]) begin
        r.rom_address = rrbm_pkg::ROM_ADDR_W'(acc.bus_address);
      end else begin
        r.rom_address = {rom_bank_sel[slot] & rom_mask, acc.bus_address[13:0]};
      end
    end else begin
      r.source = rrbm_pkg::SRC_DATA;
      if (acc.bus_address[15:13] == rrbm_pkg::RGN_EXT_RAM && ram_usable) begin
        r.read_data = ram_image[slot][ram_entry(slot, acc.bus_address)];
      end else begin
        r.read_data = rrbm_pkg::OPEN_BUS;
      end
    end
    return r;
  endfunction

  task automatic queue_access(logic action, logic [15:0] addr, logic [7:0] data);
    access_t acc;
    acc.action = action;
    acc.bus_address = addr;
    acc.write_data = data;
    // A live read of a never-written RAM entry becomes a write of that entry.
    if (action == rrbm_pkg::ACT_READ && addr[15:13] == rrbm_pkg::RGN_EXT_RAM
        && ram_enabled[PLAN] && ram_fitted && !ram_written[ram_entry(PLAN, addr)]) begin
      acc.action = rrbm_pkg::ACT_WRITE;
    end
    if (acc.action == rrbm_pkg::ACT_WRITE && addr[15:13] == rrbm_pkg::RGN_EXT_RAM) begin
      recent_ram_addrs.push_back(addr);
      if (recent_ram_addrs.size() > 16) void'(recent_ram_addrs.pop_front());
    end
    void'(map_access(PLAN, acc));
    accesses_to_send.push_back(acc);
    queued_total++;
  endtask

  task automatic queue_random_access();
    int          pick;
    logic [15:0] addr;
    logic [7:0]  data;
    pick = $urandom_range(0, 99);
    data = 8'($urandom);
    if (pick < 10) begin
      if ($urandom_range(0, 4) != 0) data = rrbm_pkg::RAM_ENABLE_KEY;
      queue_access(rrbm_pkg::ACT_WRITE, 16'($urandom_range(16'h0000, 16'h1FFF)), data);
    end else if (pick < 18) begin
      if ($urandom_range(0, 4) == 0) data[4:0] = 5'd0;
      queue_access(rrbm_pkg::ACT_WRITE, 16'($urandom_range(16'h2000, 16'h3FFF)), data);
    end else if (pick < 24) begin
      queue_access(rrbm_pkg::ACT_WRITE, 16'($urandom_range(16'h4000, 16'h5FFF)), data);
    end else if (pick < 30) begin
      queue_access(rrbm_pkg::ACT_WRITE, 16'($urandom_range(16'h6000, 16'h7FFF)), data);
    end else if (pick < 50) begin
      queue_access(rrbm_pkg::ACT_READ, 16'($urandom_range(16'h0000, 16'h7FFF)), data);
    end else if (pick < 70) begin
      queue_access(rrbm_pkg::ACT_WRITE, 16'(16'hA000 + $urandom_range(0, 16'h1FFF)), data);
    end else if (pick < 90) begin
      if (recent_ram_addrs.size() != 0 && $urandom_range(0, 2) != 0) begin
        addr = recent_ram_addrs[$urandom_range(0, recent_ram_addrs.size() - 1)];
      end else begin
        addr = 16'(16'hA000 + $urandom_range(0, 16'h1FFF));
      end
      queue_access(rrbm_pkg::ACT_READ, addr, data);
    end else begin
      queue_access(1'($urandom_range(0, 1)), 16'($urandom), data);
    end
  endtask

  task automatic wait_drained();
    while (accepted_total != queued_total || results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [rrbm_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      rrbm_pkg::CFG_ROM_BANK_MASK: rom_mask = value[4:0];
      rrbm_pkg::CFG_RAM_BANK_MASK: ram_mask = value[1:0];
      rrbm_pkg::CFG_RAM_PRESENT: ram_fitted = value[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(logic [4:0] rom_m, logic [4:0] ram_m, logic [4:0] fitted,
                           int send_pct, int recv_pct, int count, bit hold_off);
    wait_drained();
    write_register(rrbm_pkg::CFG_ROM_BANK_MASK, rom_m);
    write_register(rrbm_pkg::CFG_RAM_BANK_MASK, ram_m);
    write_register(rrbm_pkg::CFG_RAM_PRESENT, fitted);
    settings_run++;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) queue_random_access();
    if (hold_off) begin
      @(posedge clk);
      hold_request <= 1'b1;
    end
  endtask

  // Sender: holds each transaction until the mapper takes it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && in_full) full_cycles++;
      if (in_push && !in_full) begin
        results_due.push_back(map_access(LIVE, driven_access));
        accepted_total++;
      end
      if (!in_push || !in_full) begin
        if (accesses_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          driven_access = accesses_to_send.pop_front();
          in_push <= 1'b1;
          in_action <= driven_access.action;
          in_bus_address <= driven_access.bus_address;
          in_write_data <= driven_access.write_data;
        end else begin
          in_push <= 1'b0;
          in_action <= 1'($urandom_range(0, 1));
          in_bus_address <= 16'($urandom);
          in_write_data <= 8'($urandom);
        end
      end
    end
  end

  function automatic void check_field(string name, int unsigned expected, int unsigned actual);
    if (expected != actual) begin
      $display("%0t ns: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, expected,
               actual);
      error_count++;
    end
  endfunction

  // Receiver: checks each result transaction against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (results_due.size() == 0) begin
          $display("%0t ns: result with none due: expected nothing, actual source %0d",
                   $time, out_source);
          error_count++;
        end else begin
          due_result = results_due.pop_front();
          check_field("source", 32'(due_result.source), 32'(out_source));
          check_field("rom_address", 32'(due_result.rom_address), 32'(out_rom_address));
          check_field("read_data", 32'(due_result.read_data), 32'(out_read_data));
          case (due_result.source)
            rrbm_pkg::SRC_ROM: rom_fetches++;
            rrbm_pkg::SRC_DATA: data_reads++;
            default: writes_done++;
          endcase
        end
      end
      if (hold_request) begin
        hold_cycles_left = HOLD_CYCLES;
        hold_request <= 1'b0;
      end
      if (hold_cycles_left > 0) begin
        hold_cycles_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t ns: run stopped after %0d cycles with %0d results outstanding", $time,
               cycle_count, results_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < 2; s++) begin
      ram_enabled[s] = 1'b0;
      rom_bank_sel[s] = 5'd1;
      ram_bank_sel[s] = 2'd0;
      bank_mode[s] = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: window edges, bank zero remap, disabled RAM and unmapped space.
    queue_access(rrbm_pkg::ACT_READ, 16'h0000, 8'h00);
    queue_access(rrbm_pkg::ACT_READ, 16'h3FFF, 8'hFF);
    queue_access(rrbm_pkg::ACT_READ, 16'h4000, 8'h00);
    queue_access(rrbm_pkg::ACT_WRITE, 16'h2000, 8'h00);
    queue_access(rrbm_pkg::ACT_READ, 16'h7FFF, 8'h00);
    queue_access(rrbm_pkg::ACT_WRITE, 16'h3FFF, 8'hE0);
    queue_access(rrbm_pkg::ACT_READ, 16'h4000, 8'h00);
    queue_access(rrbm_pkg::ACT_WRITE, 16'h2000, 8'h1F);
    queue_access(rrbm_pkg::ACT_READ, 16'h7FFF, 8'h00);
    queue_access(rrbm_pkg::ACT_READ, 16'hA000, 8'h00);
    queue_access(rrbm_pkg::ACT_WRITE, 16'hA000, 8'h77);
    queue_access(rrbm_pkg::ACT_WRITE, 16'h7FFF, 8'hFF);
    queue_access(rrbm_pkg::ACT_WRITE, 16'h4000, 8'hFF);
    queue_access(rrbm_pkg::ACT_WRITE, 16'h0000, rrbm_pkg::RAM_ENABLE_KEY);
    queue_access(rrbm_pkg::ACT_WRITE, 16'hBFFF, 8'hA5);
    queue_access(rrbm_pkg::ACT_READ, 16'hBFFF, 8'h00);
    queue_access(rrbm_pkg::ACT_WRITE, 16'h6000, 8'h00);
    queue_access(rrbm_pkg::ACT_WRITE, 16'hA000, 8'h00);
    queue_access(rrbm_pkg::ACT_READ, 16'hA000, 8'h00);
    queue_access(rrbm_pkg::ACT_READ, 16'h8000, 8'h00);
    queue_access(rrbm_pkg::ACT_READ, 16'hFFFF, 8'h00);
    queue_access(rrbm_pkg::ACT_WRITE, 16'hE000, 8'h55);
    queue_access(rrbm_pkg::ACT_WRITE, 16'h1FFF, 8'h0B);
    queue_access(rrbm_pkg::ACT_READ, 16'hBFFF, 8'h00);
    queue_access(rrbm_pkg::ACT_WRITE, 16'h2000, 8'h03);

    run_phase(5'd31, 5'd3, 5'd1, 36, 58, 300, 1'b0);
    run_phase(5'd0, 5'd0, 5'd1, 36, 58, 200, 1'b0);
    run_phase(5'($urandom), 5'($urandom), 5'd1, 58, 36, 250, 1'b0);
    run_phase(5'd31, 5'd3, 5'd0, 58, 36, 150, 1'b0);
    // The receiver stalls long enough here for the mapper to back up.
    run_phase(5'd31, 5'd3, 5'd1, 0, 0, 300, 1'b1);
    run_phase(5'($urandom), 5'($urandom), 5'($urandom), 0, 0, 200, 1'b0);
    wait_drained();

    $display("Checked %0d results: %0d ROM fetches, %0d data reads, %0d writes.",
             rom_fetches + data_reads + writes_done, rom_fetches, data_reads, writes_done);
    $display("Covered %0d register settings; input side stalled on %0d cycles.",
             settings_run, full_cycles);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/rrbm_pkg.sv
hw/rtl/rrbm_fifo.sv
hw/rtl/rrbm_front.sv
hw/rtl/rrbm_back.sv
hw/rtl/rom_ram_bank_mapper.sv
bench/rom_ram_bank_mapper_test.sv
